// ===== rtl/core/flc_pkg.sv =====
// Shared constants, types and helpers for the FIR linear convolution block.
`timescale 1ns / 1ps

package flc_pkg;

  localparam int MAX_TAPS_DEF     = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int NUM_TAPS_W       = 5;
  localparam int TAP_IDX_W        = 4;
  localparam int RES_W            = 36;
  // running sum is held inside +-2^40, which needs 42 signed bits
  localparam int LIM_EXP          = 40;
  localparam int ACC_W            = LIM_EXP + 2;

  // word kinds on s_axis_tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  // travels with each partial sum down the chain
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  function automatic logic [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
    lo = {{(ACC_W-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}};
    if (a > hi) begin
      return hi[RES_W-1:0];
    end else if (a < lo) begin
      return lo[RES_W-1:0];
    end else begin
      return a[RES_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/flc_cell.sv =====
// One tap cell: delay line entry, coefficient, product pipe and saturating add stage.
`timescale 1ns / 1ps

module flc_cell #(
  parameter int SAMPLE_WIDTH = flc_pkg::SAMPLE_WIDTH_DEF,
  parameter int DEPTH        = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              step,
  input  logic                              clear,
  input  logic        [SAMPLE_WIDTH-1:0]    x_in,
  output logic        [SAMPLE_WIDTH-1:0]    x_out,
  input  logic                              tap_we,
  input  logic        [SAMPLE_WIDTH-1:0]    tap_wdata,
  input  logic                              use_tap,
  input  logic signed [flc_pkg::ACC_W-1:0]  acc_in,
  input  flc_pkg::tag_t                     tag_in,
  output logic signed [flc_pkg::ACC_W-1:0]  acc_out,
  output flc_pkg::tag_t                     tag_out
);
  import flc_pkg::*;

  localparam int PW    = 2 * SAMPLE_WIDTH;
  localparam int SUM_W = ((PW > ACC_W) ? PW : ACC_W) + 1;
  localparam logic signed [SUM_W-1:0] POS_LIM =
    {{(SUM_W-LIM_EXP-1){1'b0}}, 1'b1, {LIM_EXP{1'b0}}};
  localparam logic signed [SUM_W-1:0] NEG_LIM = -POS_LIM;

  logic        [SAMPLE_WIDTH-1:0] tap;
  logic        [SAMPLE_WIDTH-1:0] hold;
  logic signed [PW-1:0]           pipe [DEPTH];
  logic signed [PW-1:0]           prod;
  logic signed [SUM_W-1:0]        sum;
  logic signed [SUM_W-1:0]        sat;

  assign x_out = hold;
  assign prod  = $signed(tap) * $signed(x_in);
  assign sum   = SUM_W'(acc_in) + SUM_W'(pipe[DEPTH-1]);

  always_comb begin
    if (sum > POS_LIM) begin
      sat = POS_LIM;
    end else if (sum < NEG_LIM) begin
      sat = NEG_LIM;
    end else begin
      sat = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (tap_we) begin
      tap <= tap_wdata;
    end
  end

  // delay line entry moves only when a sample or a tail zero steps in
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
    end else if (step) begin
      hold <= clear ? '0 : x_in;
    end
  end

  // product waits here until its partial sum reaches this cell
  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= use_tap ? prod : '0;
      for (int j = 1; j < DEPTH; j++) begin
        pipe[j] <= pipe[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_out <= sat[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (adv) begin
      tag_out <= tag_in;
    end
  end

endmodule

// ===== rtl/core/flc_skid.sv =====
// Output register with skid entry, registered ready toward the chain.
`timescale 1ns / 1ps

module flc_skid #(
  parameter int WIDTH = flc_pkg::RES_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import flc_pkg::*;

  logic             sk_valid;
  logic [WIDTH-1:0] sk_data;
  logic             in_fire;
  logic             load;

  assign in_ready = !sk_valid;
  assign in_fire  = in_valid && !sk_valid;
  assign load     = out_ready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (load) begin
      out_valid <= sk_valid || in_fire;
      sk_valid  <= 1'b0;
    end else if (in_fire) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sk_valid) begin
        out_data <= sk_data;
      end else if (in_fire) begin
        out_data <= in_data;
      end
    end else if (in_fire) begin
      sk_data <= in_data;
    end
  end

endmodule

// ===== rtl/core/fir_linear_convolution.sv =====
// Top level: FIR full linear convolution over a chain of tap cells.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata, tuser = kind, tlast = block end
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata = result, tlast = run last
//   cfg       in         cfg_valid/cfg_ready          cfg_data = num_taps
//
// One word accepted per cycle while the chain is not frozen and no tail is running; a result
// passes the product stage, one add stage per cell, the final clamp and the output register.
// A block-end sample holds s_axis_tready low while the chain is fed the effective tap count
// minus one zero samples for the tail results.
// Synchronous reset clears taps, the delay line and sets num_taps to MAX_TAPS.
// When m_axis stalls, the skid entry fills and the whole chain freezes.
`timescale 1ns / 1ps

module fir_linear_convolution #(
  parameter int MAX_TAPS     = flc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = flc_pkg::SAMPLE_WIDTH_DEF,
  localparam int IN_W  = ((SAMPLE_WIDTH + flc_pkg::TAP_IDX_W + 7) / 8) * 8,
  localparam int OUT_W = ((flc_pkg::RES_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [IN_W-1:0]                  s_axis_tdata,  // value, tap_index, zero pad
  input  logic                             s_axis_tuser,  // req_type
  input  logic                             s_axis_tlast,  // block_end
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [OUT_W-1:0]                 m_axis_tdata,  // result_value, zero pad
  output logic                             m_axis_tlast,  // run_last
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [flc_pkg::NUM_TAPS_W-1:0]   cfg_data
);
  import flc_pkg::*;

  localparam int NT_W_MIN = $clog2(MAX_TAPS + 1);
  localparam int NT_W     = (NT_W_MIN > NUM_TAPS_W) ? NT_W_MIN : NUM_TAPS_W;
  localparam int CNT_W    = $clog2(MAX_TAPS);

  logic [NT_W-1:0]          num_taps;
  logic [NT_W-1:0]          nt;
  logic [SAMPLE_WIDTH-1:0]  value;
  logic [TAP_IDX_W-1:0]     tap_index;
  logic                     adv;
  logic                     s_fire;
  logic                     samp_fire;
  logic                     coef_fire;
  logic                     tail_active;
  logic [CNT_W-1:0]         tail_rem;
  logic                     tail_step;
  logic                     step;
  logic                     step_last;
  logic                     one_tap;
  tag_t                     head;
  tag_t                     fin_tag;
  logic [RES_W-1:0]         fin_res;
  logic [RES_W-1:0]         out_res;
  logic                     out_last;

  logic        [SAMPLE_WIDTH-1:0] xs   [MAX_TAPS+1];
  logic signed [ACC_W-1:0]        accs [MAX_TAPS+1];
  tag_t                           tags [MAX_TAPS+1];

  assign value     = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign tap_index = s_axis_tdata[SAMPLE_WIDTH +: TAP_IDX_W];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_taps <= NT_W'(MAX_TAPS);
    end else if (cfg_valid && cfg_ready) begin
      num_taps <= NT_W'(cfg_data);
    end
  end

  // zero acts as one tap, anything beyond the chain as the full chain
  always_comb begin
    if (num_taps == '0) begin
      nt = NT_W'(1);
    end else if (num_taps > NT_W'(MAX_TAPS)) begin
      nt = NT_W'(MAX_TAPS);
    end else begin
      nt = num_taps;
    end
  end

  assign one_tap       = (nt == NT_W'(1));
  assign s_axis_tready = adv && !tail_active;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign samp_fire     = s_fire && (s_axis_tuser == REQ_SAMPLE);
  assign coef_fire     = s_fire && (s_axis_tuser == REQ_COEF);
  assign tail_step     = tail_active && adv;
  assign step          = samp_fire || tail_step;
  assign step_last     = tail_active ? (tail_rem == CNT_W'(1)) : (s_axis_tlast && one_tap);
  assign xs[0]         = tail_active ? '0 : value;

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_active <= 1'b0;
      tail_rem    <= '0;
    end else if (samp_fire && s_axis_tlast && !one_tap) begin
      tail_active <= 1'b1;
      tail_rem    <= CNT_W'(nt - NT_W'(1));
    end else if (tail_step) begin
      tail_rem <= tail_rem - CNT_W'(1);
      if (tail_rem == CNT_W'(1)) begin
        tail_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (adv) begin
      head.valid <= step;
      head.last  <= step && step_last;
    end
  end

  assign accs[0] = '0;
  assign tags[0] = head;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    flc_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .DEPTH        (k + 1)
    ) u_tap (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .step      (step),
      .clear     (step_last),
      .x_in      (xs[k]),
      .x_out     (xs[k+1]),
      .tap_we    (coef_fire && (32'(tap_index) == 32'(k))),
      .tap_wdata (value),
      .use_tap   (NT_W'(k) < nt),
      .acc_in    (accs[k]),
      .tag_in    (tags[k]),
      .acc_out   (accs[k+1]),
      .tag_out   (tags[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_tag <= '0;
    end else if (adv) begin
      fin_tag <= tags[MAX_TAPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_res <= sat_res(accs[MAX_TAPS]);
    end
  end

  flc_skid #(
    .WIDTH (RES_W + 1)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fin_tag.valid),
    .in_ready  (adv),
    .in_data   ({fin_tag.last, fin_res}),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  ({out_last, out_res})
  );

  assign m_axis_tdata = OUT_W'(out_res);
  assign m_axis_tlast = out_last;

  // a block end with more than one tap must start the zero tail
  a_tail_start: assert property (@(posedge clk) disable iff (rst)
    (samp_fire && s_axis_tlast && !one_tap) |=> tail_active)
    else $error("tail not started after block end");

  a_tail_count: assert property (@(posedge clk) disable iff (rst)
    tail_active |-> (tail_rem != '0))
    else $error("tail active with empty count");

  // the last result of a block leaves the delay line silent
  a_dl_cleared: assert property (@(posedge clk) disable iff (rst)
    (step && step_last) |=> (xs[1] == '0))
    else $error("delay line not cleared at block end");

  a_head_last: assert property (@(posedge clk) disable iff (rst)
    head.last |-> head.valid)
    else $error("run_last tag on empty slot");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the FIR linear convolution block.
`timescale 1ns / 1ps

module testbench;
  import flc_pkg::*;

  localparam int MAX_TAPS     = MAX_TAPS_DEF;
  localparam int SAMPLE_W     = SAMPLE_WIDTH_DEF;
  localparam int IN_W         = ((SAMPLE_W + TAP_IDX_W + 7) / 8) * 8;
  localparam int OUT_W        = ((RES_W + 7) / 8) * 8;
  localparam int LATENCY      = MAX_TAPS + 3;
  localparam int DRAIN_CYCLES = 2 * LATENCY + 8;
  localparam int ITEM_TARGET  = 330;

  typedef enum logic [1:0] {WORD_SAMPLE, WORD_COEF, WORD_TAPS_CFG} word_kind_t;

  typedef struct {
    word_kind_t               kind;
    logic signed [SAMPLE_W-1:0] value;
    logic [TAP_IDX_W-1:0]     tap;
    logic                     block_end;
    logic [NUM_TAPS_W-1:0]    taps;
    int                       gap;
  } stim_word_t;

  typedef struct {
    logic signed [RES_W-1:0] sum;
    logic                    last;
  } conv_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  s_axis_tuser = REQ_SAMPLE;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [NUM_TAPS_W-1:0] cfg_data = '0;

  fir_linear_convolution dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic signed [SAMPLE_W-1:0] tap_coef     [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] past_samples [MAX_TAPS-1];
  logic [NUM_TAPS_W-1:0]      taps_reg;

  stim_word_t   stim_words [$];
  conv_result_t pending_sums [$];
  int           fail_count = 0;
  int           item_count = 0;
  bit           phase_calm = 1'b0;

  function automatic int taps_in_use();
    if (taps_reg == 0) return 1;
    if (int'(taps_reg) > MAX_TAPS) return MAX_TAPS;
    return int'(taps_reg);
  endfunction

  function automatic longint clamp_acc(input longint a);
    longint lim;
    lim = longint'(1) << LIM_EXP;
    if (a > lim) return lim;
    if (a < -lim) return -lim;
    return a;
  endfunction

  // shift one sample into the delay line, return the clamped sum of products
  function automatic logic signed [RES_W-1:0] fir_shift_in(input logic signed [SAMPLE_W-1:0] x,
                                                          input int nt);
    longint acc;
    longint hi;
    longint lo;
    hi  = (longint'(1) << (RES_W - 1)) - 1;
    lo  = -(longint'(1) << (RES_W - 1));
    acc = clamp_acc(longint'(tap_coef[0]) * longint'(x));
    for (int k = 1; k < nt; k++) begin
      acc = clamp_acc(acc + longint'(tap_coef[k]) * longint'(past_samples[k-1]));
    end
    for (int k = MAX_TAPS - 2; k > 0; k--) begin
      past_samples[k] = past_samples[k-1];
    end
    past_samples[0] = x;
    if (acc > hi) acc = hi;
    if (acc < lo) acc = lo;
    return acc[RES_W-1:0];
  endfunction

  function automatic void push_sum(input logic signed [RES_W-1:0] s, input logic last);
    conv_result_t r;
    r.sum  = s;
    r.last = last;
    pending_sums.push_back(r);
  endfunction

  function automatic void predict_word(input stim_word_t w);
    int nt;
    nt = taps_in_use();
    if (w.kind == WORD_COEF) begin
      if (int'(w.tap) < MAX_TAPS) tap_coef[w.tap] = w.value;
    end else begin
      push_sum(fir_shift_in(w.value, nt), w.block_end && nt == 1);
      if (w.block_end) begin
        for (int t = 1; t < nt; t++) begin
          push_sum(fir_shift_in('0, nt), t == nt - 1);
        end
        for (int k = 0; k < MAX_TAPS - 1; k++) past_samples[k] = '0;
      end
    end
  endfunction

  function automatic int draw_gap();
    if (phase_calm) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      2:       return '0;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_extreme();
    if ($urandom_range(0, 1) != 0) return {1'b1, {(SAMPLE_W-1){1'b0}}};
    return {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

  function automatic void add_sample(input logic signed [SAMPLE_W-1:0] v, input logic blk_end);
    stim_word_t w;
    w.kind      = WORD_SAMPLE;
    w.value     = v;
    w.tap       = TAP_IDX_W'($urandom());
    w.block_end = blk_end;
    w.taps      = '0;
    w.gap       = draw_gap();
    stim_words.push_back(w);
    item_count++;
  endfunction

  function automatic void add_coef(input int idx, input logic signed [SAMPLE_W-1:0] v);
    stim_word_t w;
    w.kind      = WORD_COEF;
    w.value     = v;
    w.tap       = idx[TAP_IDX_W-1:0];
    w.block_end = 1'($urandom_range(0, 1));
    w.taps      = '0;
    w.gap       = draw_gap();
    stim_words.push_back(w);
    item_count++;
  endfunction

  function automatic void add_taps_cfg(input int n);
    stim_word_t w;
    w.kind      = WORD_TAPS_CFG;
    w.value     = '0;
    w.tap       = '0;
    w.block_end = 1'b0;
    w.taps      = n[NUM_TAPS_W-1:0];
    w.gap       = draw_gap();
    stim_words.push_back(w);
  endfunction

  // driver
  stim_word_t cur_word;
  stim_word_t nxt_word;
  bit         send_on;
  bit         cfg_on;
  int         gap_left;
  int         quiet;

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_TAPS; k++) tap_coef[k] = '0;
      for (int k = 0; k < MAX_TAPS - 1; k++) past_samples[k] = '0;
      taps_reg = NUM_TAPS_W'(MAX_TAPS);
      gap_left = 0;
      quiet    = 0;
      s_axis_tvalid <= 1'b0;
      cfg_valid     <= 1'b0;
    end else begin
      send_on = s_axis_tvalid;
      cfg_on  = cfg_valid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(cur_word);
        send_on = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        taps_reg = cfg_data;
        cfg_on   = 1'b0;
      end
      if (send_on || pending_sums.size() != 0 || (s_axis_tvalid && s_axis_tready)) begin
        quiet = 0;
      end else if (quiet < DRAIN_CYCLES) begin
        quiet++;
      end
      if (!send_on && !cfg_on) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_words.size() != 0) begin
          nxt_word = stim_words[0];
          if (nxt_word.kind == WORD_TAPS_CFG) begin
            // register writes only once the pipeline has fully drained
            if (quiet >= DRAIN_CYCLES) begin
              void'(stim_words.pop_front());
              cfg_data <= nxt_word.taps;
              cfg_on   = 1'b1;
              gap_left = nxt_word.gap;
            end
          end else begin
            void'(stim_words.pop_front());
            cur_word = nxt_word;
            s_axis_tdata <= IN_W'({nxt_word.tap, nxt_word.value});
            s_axis_tuser <= (nxt_word.kind == WORD_COEF) ? REQ_COEF : REQ_SAMPLE;
            s_axis_tlast <= nxt_word.block_end;
            send_on  = 1'b1;
            gap_left = nxt_word.gap;
          end
        end
      end
      s_axis_tvalid <= send_on;
      cfg_valid     <= cfg_on;
    end
  end

  // monitor
  conv_result_t            want;
  logic signed [RES_W-1:0] got_sum;
  bit                      rdy_on;
  int                      stall_left;
  int                      calm_left;

  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      calm_left  = 0;
      m_axis_tready <= 1'b0;
    end else begin
      rdy_on = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got_sum = $signed(m_axis_tdata[RES_W-1:0]);
        if (pending_sums.size() == 0) begin
          $error("unexpected result word: result_value %0d run_last %0b", got_sum, m_axis_tlast);
          fail_count++;
        end else begin
          want = pending_sums.pop_front();
          if (got_sum !== want.sum) begin
            $error("result_value: expected %0d, actual %0d", want.sum, got_sum);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("run_last: expected %0b, actual %0b", want.last, m_axis_tlast);
            fail_count++;
          end
        end
        if (calm_left > 0) begin
          calm_left--;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 16);
          if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
        end
        if (stall_left > 0) rdy_on = 1'b0;
      end else if (!m_axis_tready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) rdy_on = 1'b1;
      end
      m_axis_tready <= rdy_on;
    end
  end

  // stimulus and end of run
  initial begin
    int                         n;
    int                         mode;
    int                         len;
    logic signed [SAMPLE_W-1:0] ext;

    // directed: extremes, ignored fields, single-tap and out-of-range lengths
    add_coef(0, {1'b1, {(SAMPLE_W-1){1'b0}}});
    add_coef(MAX_TAPS - 1, {1'b0, {(SAMPLE_W-1){1'b1}}});
    add_coef(7, SAMPLE_W'(1));
    add_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
    add_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
    add_sample(SAMPLE_W'(1), 1'b1);
    add_taps_cfg(1);
    add_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b1);
    add_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
    add_taps_cfg(0);
    add_sample(SAMPLE_W'(12345), 1'b1);
    add_taps_cfg(31);
    add_sample(SAMPLE_W'(-1), 1'b1);
    add_taps_cfg(2);
    add_sample(SAMPLE_W'(-300), 1'b0);
    add_sample(SAMPLE_W'(300), 1'b1);
    add_taps_cfg(MAX_TAPS);
    add_sample(SAMPLE_W'(-2), 1'b1);

    while (item_count < ITEM_TARGET) begin
      phase_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       n = 0;
        1:       n = 1;
        2:       n = MAX_TAPS;
        3:       n = 31;
        4:       n = 2;
        default: n = $urandom_range(0, 31);
      endcase
      add_taps_cfg(n);
      mode = $urandom_range(0, 5);
      ext  = draw_extreme();
      if (mode == 0) begin
        // full-scale taps and samples drive the largest sums
        for (int k = 0; k < MAX_TAPS; k++) add_coef(k, ext);
      end else if (mode == 1) begin
        repeat ($urandom_range(1, 3)) add_coef($urandom_range(0, MAX_TAPS - 1), draw_value());
      end else begin
        for (int k = 0; k < MAX_TAPS; k++) add_coef(k, draw_value());
      end
      repeat ($urandom_range(1, 4)) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 11) == 0) add_coef($urandom_range(0, MAX_TAPS - 1), draw_value());
          add_sample((mode == 0) ? draw_extreme() : draw_value(), i == len - 1);
        end
      end
      // dangling samples with no block end carry history into the next phase
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) add_sample(draw_value(), 1'b0);
      end
    end
    phase_calm = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (stim_words.size() != 0 || s_axis_tvalid || cfg_valid || pending_sums.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/flc_pkg.sv
rtl/core/flc_cell.sv
rtl/core/flc_skid.sv
rtl/core/fir_linear_convolution.sv
test/testbench.sv
